// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, character codes and digit tables for the Roman numeral
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

  localparam int ValueW = 12;
  localparam int SymW   = 7;
  localparam logic [ValueW-1:0] MaxValid = 12'd3999;

  // Decimal positions
  localparam logic [1:0] POS_UNITS     = 2'd0;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  // ASCII Roman characters
  localparam logic [SymW-1:0] CH_NONE = 7'h00;
  localparam logic [SymW-1:0] CH_I    = 7'h49;
  localparam logic [SymW-1:0] CH_V    = 7'h56;
  localparam logic [SymW-1:0] CH_X    = 7'h58;
  localparam logic [SymW-1:0] CH_L    = 7'h4C;
  localparam logic [SymW-1:0] CH_C    = 7'h43;
  localparam logic [SymW-1:0] CH_D    = 7'h44;
  localparam logic [SymW-1:0] CH_M    = 7'h4D;

  // Which letter of a position a character uses
  typedef enum logic [1:0] {
    SEL_ONE  = 2'd0,
    SEL_FIVE = 2'd1,
    SEL_TEN  = 2'd2
  } sel_t;

  // k * 10^pos, k = 0..9, indexed [pos][k]
  localparam logic [13:0] MULT_TABLE [4][10] = '{
    '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9},
    '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40, 14'd50, 14'd60, 14'd70, 14'd80,
      14'd90},
    '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400, 14'd500, 14'd600, 14'd700,
      14'd800, 14'd900},
    '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000,
      14'd7000, 14'd8000, 14'd9000}
  };

  // Controller to datapath
  typedef struct packed {
    logic load;          // take a new request, split off the thousands
    logic extract;       // split off the next lower digit
    logic advance;       // step to the next character of the digit
    logic show_char;     // present the current character
    logic show_special;  // present the single zero / out-of-range result
  } i2r_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_special;    // request value is zero or above the valid range
    logic in_digit_zero; // thousands digit of the request is zero
    logic next_zero;     // next lower digit is zero
    logic char_final;    // current character ends its digit
    logic rest_zero;     // nothing left below the current digit
  } i2r_status_t;

  typedef struct packed {
    logic [3:0]        digit;
    logic [ValueW-1:0] rem;
  } split_t;

  // One decimal digit off the top: nine parallel trial subtractions
  function automatic split_t digit_split(input logic [ValueW-1:0] rest,
                                         input logic [1:0] pos);
    split_t       res;
    logic [13:0]  diff;
    res.digit = 4'd0;
    res.rem   = rest;
    for (int k = 1; k < 10; k++) begin
      diff = {2'b00, rest} - MULT_TABLE[pos][k];
      if ({2'b00, rest} >= MULT_TABLE[pos][k]) begin
        res.digit = 4'(k);
        res.rem   = diff[ValueW-1:0];
      end
    end
    return res;
  endfunction

  // Index of the final character of a digit's pattern
  function automatic logic [1:0] final_idx(input logic [3:0] digit);
    logic [1:0] f;
    case (digit)
      4'd2, 4'd4, 4'd6, 4'd9: f = 2'd1;
      4'd3, 4'd7:             f = 2'd2;
      4'd8:                   f = 2'd3;
      default:                f = 2'd0;
    endcase
    return f;
  endfunction

  // Character at place idx of digit at position pos
  function automatic logic [SymW-1:0] roman_char(input logic [3:0] digit,
                                                 input logic [1:0] idx,
                                                 input logic [1:0] pos);
    sel_t            sel;
    logic [SymW-1:0] ch;
    sel = SEL_ONE;
    case (digit)
      4'd4:                   sel = (idx == 2'd0) ? SEL_ONE : SEL_FIVE;
      4'd5:                   sel = SEL_FIVE;
      4'd6, 4'd7, 4'd8:       sel = (idx == 2'd0) ? SEL_FIVE : SEL_ONE;
      4'd9:                   sel = (idx == 2'd0) ? SEL_ONE : SEL_TEN;
      default:                sel = SEL_ONE;
    endcase
    case (pos)
      POS_UNITS:    ch = (sel == SEL_ONE) ? CH_I : (sel == SEL_FIVE) ? CH_V : CH_X;
      POS_TENS:     ch = (sel == SEL_ONE) ? CH_X : (sel == SEL_FIVE) ? CH_L : CH_C;
      POS_HUNDREDS: ch = (sel == SEL_ONE) ? CH_C : (sel == SEL_FIVE) ? CH_D : CH_M;
      default:      ch = CH_M;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/i2r_dp.sv
// ----------------------------------------------------------------------------
// i2r_dp
// Datapath: remainder, current digit, position and character index, plus
// the character lookup that drives the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_dp (
  input  wire logic                       clk,
  input  wire logic [i2r_pkg::ValueW-1:0] value,
  input  wire i2r_pkg::i2r_cmd_t          cmd,
  output i2r_pkg::i2r_status_t            status,
  output logic [i2r_pkg::SymW-1:0]        symbol,
  output logic                            last,
  output logic                            out_of_range
);
  import i2r_pkg::*;

  logic [ValueW-1:0] rest;
  logic [3:0]        digit;
  logic [1:0]        pos;
  logic [1:0]        idx;
  logic              oor;

  split_t            in_split;
  split_t            next_split;
  logic [1:0]        pos_dn;
  logic              char_final;

  // Digit split of the incoming value and of the held remainder
  always_comb begin
    pos_dn     = pos - 2'd1;
    in_split   = digit_split(value, POS_THOUSANDS);
    next_split = digit_split(rest, pos_dn);
    char_final = (idx == final_idx(digit));
  end

  // Working registers, payload only
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest  <= in_split.rem;
      digit <= in_split.digit;
      pos   <= POS_THOUSANDS;
      idx   <= 2'd0;
      oor   <= (value > MaxValid);
    end else if (cmd.extract) begin
      rest  <= next_split.rem;
      digit <= next_split.digit;
      pos   <= pos_dn;
      idx   <= 2'd0;
    end else if (cmd.advance) begin
      idx   <= idx + 2'd1;
    end
  end

  // Status back to the controller
  always_comb begin
    status.in_special    = (value == '0) || (value > MaxValid);
    status.in_digit_zero = (in_split.digit == 4'd0);
    status.next_zero     = (next_split.digit == 4'd0);
    status.char_final    = char_final;
    status.rest_zero     = (rest == '0);
  end

  // Result ports
  always_comb begin
    symbol       = cmd.show_char ? roman_char(digit, idx, pos) : CH_NONE;
    last         = cmd.show_special || (char_final && (rest == '0));
    out_of_range = cmd.show_special && oor;
  end

endmodule

`default_nettype wire

// File: rtl/i2r_ctrl.sv
// ----------------------------------------------------------------------------
// i2r_ctrl
// Controller: sequences request load, digit extraction and character
// emission.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire i2r_pkg::i2r_status_t status,
  output i2r_pkg::i2r_cmd_t         cmd,
  output logic                      busy,
  output logic                      strobe
);
  import i2r_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_DIGIT   = 4'b0010,
    ST_EMIT    = 4'b0100,
    ST_SPECIAL = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    strobe     = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (status.in_special) begin
            state_next = ST_SPECIAL;
          end else if (status.in_digit_zero) begin
            state_next = ST_DIGIT;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIGIT: begin
        // skip a zero digit; something nonzero is still below
        cmd.extract = 1'b1;
        state_next  = status.next_zero ? ST_DIGIT : ST_EMIT;
      end
      ST_EMIT: begin
        strobe        = 1'b1;
        cmd.show_char = 1'b1;
        if (!status.char_final) begin
          cmd.advance = 1'b1;
        end else if (status.rest_zero) begin
          state_next = ST_IDLE;
        end else begin
          cmd.extract = 1'b1;
          state_next  = status.next_zero ? ST_DIGIT : ST_EMIT;
        end
      end
      ST_SPECIAL: begin
        strobe           = 1'b1;
        cmd.show_special = 1'b1;
        state_next       = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/integer_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a 12-bit unsigned value to its Roman numeral, one ASCII
// character per result.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive value and raise start while busy is low; the request is
//   taken at that clock edge and busy rises in the next cycle.
//   Results: one character per cycle on symbol, marked by strobe, thousands
//   first, pausing for skipped zero digits; last flags the final character.
//   The receiver cannot hold results off, so strobe is never stalled.
//   Zero gives one result with symbol 0 and last set. 4000..4095 gives one
//   result with symbol 0, last and out_of_range set.
// Timing:
//   The first result appears in the cycle after the request edge when the
//   thousands digit is nonzero; zero digits ahead of a character are skipped
//   in ST_DIGIT. A request passes ST_EMIT for each character and ST_DIGIT
//   for each skipped zero digit; 3888 gives 15 characters. busy falls in the
//   cycle after the final result, so the next request can be taken then.
//   The character sequencer sets the pace: one character per ST_EMIT cycle.
// Reset: rst (synchronous) returns the controller to idle; any conversion
//   in flight is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module integer_to_roman_numeral (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [i2r_pkg::ValueW-1:0] value,
  output logic                            busy,
  output logic                            strobe,
  output logic [i2r_pkg::SymW-1:0]        symbol,
  output logic                            last,
  output logic                            out_of_range
);
  import i2r_pkg::*;

  i2r_cmd_t    cmd;
  i2r_status_t status;

  i2r_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  i2r_dp u_dp (
    .clk          (clk),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .symbol       (symbol),
    .last         (last),
    .out_of_range (out_of_range)
  );

  // Checks
  `ASSERT_IMP(a_strobe_busy, clk, rst, strobe, busy, "result outside a request")
  `ASSERT_NXT(a_take_busy, clk, rst, start && !busy, busy, "request not taken")
  `ASSERT_IMP(a_oor_form, clk, rst, strobe && out_of_range,
              last && (symbol == CH_NONE), "out-of-range result malformed")
  `ASSERT_NXT(a_last_idle, clk, rst, strobe && last, !busy, "busy after final result")

endmodule

`default_nettype wire
